[src/dma_descriptor_table_builder_assert.svh]
// Assertion macros for the descriptor table builder.
`ifndef DMA_DESCRIPTOR_TABLE_BUILDER_ASSERT_SVH
`define DMA_DESCRIPTOR_TABLE_BUILDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DDTB_ASSERT_IMPLIES(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DDTB_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

[src/ddtb_pkg.sv]
// Shared types, constants and status codes for the descriptor table builder.
`default_nettype none
package ddtb_pkg;

   localparam int ADDR_W      = 32;
   localparam int BLEN_W      = 20;
   localparam int ELEN_W      = 16;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 56;
   localparam int RSP_TUSER_W = 3;

   // Default table capacity
   localparam int MAX_ENTRIES_DEF = 8;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_LEN = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic emit;
   } ddtb_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;
      logic entry_last;
   } ddtb_stat_type;

endpackage
`default_nettype wire

[src/ddtb_ctrl.sv]
// Controller state machine: accepts a request, then sequences entry emission.
`default_nettype none
module ddtb_ctrl
   import ddtb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire ddtb_stat_type stat,
   output ddtb_cmd_type       cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;

   logic state_ff;
   logic state_in;

   // Take a new request only when no table is being built
   assign req_tready = (state_ff == ST_IDLE);

   // Decode commands and next state
   always_comb begin
      cmd.load = 1'b0;
      cmd.emit = 1'b0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.entry_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[src/ddtb_datapath.sv]
// Datapath: address and length walk, chunk split, and the result register.
`default_nettype none
module ddtb_datapath
   import ddtb_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [ADDR_W-1:0]      start_address,
   input  wire logic [BLEN_W-1:0]      byte_length,
   input  wire ddtb_cmd_type           cmd,
   output ddtb_stat_type               stat,
   input  wire logic                   rsp_tready,
   output logic                        rsp_valid,
   output logic                        entry_valid,
   output logic [ADDR_W-1:0]           entry_base,
   output logic [ELEN_W-1:0]           entry_length,
   output logic                        end_of_table,
   output logic [STATUS_W-1:0]         status,
   output logic                        last
);

   localparam int CNT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_ENTRIES - 1);

   // Walk registers
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [BLEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                ent_valid_ff;
   logic [ADDR_W-1:0]   ent_base_ff;
   logic [ELEN_W-1:0]   ent_len_ff;
   logic                eot_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                last_ff;

   logic [ELEN_W:0]   room;
   logic [ELEN_W:0]   chunk;
   logic [BLEN_W-1:0] after;
   logic              zero_len;
   logic              final_ent;
   logic              overflow;

   // Split the next chunk at the 64 KiB boundary or the buffer end
   always_comb begin
      room      = {1'b1, {ELEN_W{1'b0}}} - {1'b0, addr_ff[ELEN_W-1:0]};
      chunk     = (rem_ff < BLEN_W'(room)) ? rem_ff[ELEN_W:0] : room;
      after     = rem_ff - BLEN_W'(chunk);
      zero_len  = (rem_ff == '0);
      final_ent = (after == '0);
      overflow  = !final_ent && (cnt_ff == CNT_LAST);
   end

   assign stat.out_free   = !rsp_valid_ff || rsp_tready;
   assign stat.entry_last = zero_len || final_ent || overflow;

   // Advance the walk
   always_comb begin
      addr_in = addr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (cmd.load) begin
         addr_in = start_address;
         rem_in  = byte_length;
         cnt_in  = '0;
      end else if (cmd.emit) begin
         addr_in = addr_ff + ADDR_W'(chunk);
         rem_in  = after;
         cnt_in  = cnt_ff + 1'b1;
      end
   end

   // Hold the result until the sink takes the transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      if (cmd.emit) begin
         if (zero_len) begin
            ent_valid_ff <= 1'b0;
            ent_base_ff  <= '0;
            ent_len_ff   <= '0;
            eot_ff       <= 1'b0;
            status_ff    <= STATUS_ZERO_LEN;
            last_ff      <= 1'b1;
         end else begin
            ent_valid_ff <= 1'b1;
            ent_base_ff  <= addr_ff;
            ent_len_ff   <= chunk[ELEN_W-1:0];
            eot_ff       <= final_ent;
            status_ff    <= overflow ? STATUS_OVERFLOW : STATUS_OK;
            last_ff      <= final_ent || overflow;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign entry_valid  = ent_valid_ff;
   assign entry_base   = ent_base_ff;
   assign entry_length = ent_len_ff;
   assign end_of_table = eot_ff;
   assign status       = status_ff;
   assign last         = last_ff;

endmodule
`default_nettype wire

[src/dma_descriptor_table_builder.sv]
// Top level of the descriptor table builder: stream ports, controller and datapath.
//
//  channel | direction | tdata (low bit up)                         | tuser / tlast
//  req_    | in        | start_address[31:0], byte_length[19:0], pad | -
//  rsp_    | out       | entry_base, entry_length, end_of_table, pad | entry_valid, status; last
//
//  One request yields 1 to MAX_ENTRIES results from the result register, one per cycle
//  while the sink does not stall. The next request is taken in the cycle after the last
//  entry is computed.
//  Reset is synchronous and clears the controller state and the result valid.
//  A sink stall holds the result register and pauses the address walk.
`default_nettype none
module dma_descriptor_table_builder
   import ddtb_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [31:0] start_address, [51:32] byte_length, [55:52] zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [31:0] entry_base, [47:32] entry_length, [48] end_of_table, [55:49] zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // [0] entry_valid, [2:1] status
   output logic [RSP_TUSER_W-1:0]      rsp_tuser,
   output logic                        rsp_tlast
);

   ddtb_cmd_type        cmd;
   ddtb_stat_type       stat;
   logic                entry_valid;
   logic [ADDR_W-1:0]   entry_base;
   logic [ELEN_W-1:0]   entry_length;
   logic                end_of_table;
   logic [STATUS_W-1:0] status;

   ddtb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ddtb_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .start_address (req_tdata[ADDR_W-1:0]),
      .byte_length   (req_tdata[ADDR_W+BLEN_W-1:ADDR_W]),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_tready    (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .entry_valid   (entry_valid),
      .entry_base    (entry_base),
      .entry_length  (entry_length),
      .end_of_table  (end_of_table),
      .status        (status),
      .last          (rsp_tlast)
   );

   // Pack result fields
   assign rsp_tdata = {{(RSP_TDATA_W-ADDR_W-ELEN_W-1){1'b0}}, end_of_table, entry_length,
                       entry_base};
   assign rsp_tuser = {status, entry_valid};

`include "dma_descriptor_table_builder_assert.svh"

   `DDTB_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted while a table is in progress")
   `DDTB_ASSERT_IMPLIES(a_eot_is_final, clock, reset, rsp_tvalid && end_of_table, rsp_tlast && entry_valid && (status == STATUS_OK), "end-of-table on a non-final or failed entry")
   `DDTB_ASSERT_IMPLIES(a_overflow_closes, clock, reset, rsp_tvalid && (status == STATUS_OVERFLOW), rsp_tlast && entry_valid && !end_of_table, "overflow entry malformed")
   `DDTB_ASSERT_IMPLIES(a_zero_len_single, clock, reset, rsp_tvalid && (status == STATUS_ZERO_LEN), rsp_tlast && !entry_valid, "zero-length result malformed")

endmodule
`default_nettype wire
